>>> design/bcte_pkg.sv
package bcte_pkg;

  localparam int MAX_SAMPLES  = 65536;
  localparam int CORDIC_STEPS = 16;
  localparam int HIT_W        = $clog2(MAX_SAMPLES + 1);
  localparam int TSUM_W       = 48;
  localparam int LSUM_W       = 40;

  // config register indexes
  localparam logic [2:0] REG_BASELINE = 3'd0;
  localparam logic [2:0] REG_R_CENTER = 3'd1;
  localparam logic [2:0] REG_R_HALF   = 3'd2;
  localparam logic [2:0] REG_K_CENTER = 3'd3;
  localparam logic [2:0] REG_K_HALF   = 3'd4;
  localparam logic [2:0] REG_TDIV     = 3'd5;

  // running sums of one band
  typedef struct packed {
    logic [TSUM_W-1:0]        tsum;
    logic signed [LSUM_W-1:0] lsum;
    logic [HIT_W-1:0]         hits;
    logic                     closed;
  } band_t;

  // arctangent table in degrees, Q.16
  function automatic logic [21:0] atan_deg(input logic [4:0] i);
    case (i)
      5'd0:  atan_deg = 22'd2949120;
      5'd1:  atan_deg = 22'd1740967;
      5'd2:  atan_deg = 22'd919879;
      5'd3:  atan_deg = 22'd466945;
      5'd4:  atan_deg = 22'd234379;
      5'd5:  atan_deg = 22'd117304;
      5'd6:  atan_deg = 22'd58666;
      5'd7:  atan_deg = 22'd29335;
      5'd8:  atan_deg = 22'd14668;
      5'd9:  atan_deg = 22'd7334;
      5'd10: atan_deg = 22'd3667;
      5'd11: atan_deg = 22'd1833;
      5'd12: atan_deg = 22'd917;
      5'd13: atan_deg = 22'd458;
      5'd14: atan_deg = 22'd229;
      5'd15: atan_deg = 22'd115;
      5'd16: atan_deg = 22'd57;
      5'd17: atan_deg = 22'd29;
      5'd18: atan_deg = 22'd14;
      5'd19: atan_deg = 22'd7;
      5'd20: atan_deg = 22'd4;
      5'd21: atan_deg = 22'd2;
      5'd22: atan_deg = 22'd1;
      default: atan_deg = 22'd0;
    endcase
  endfunction

endpackage

>>> design/bcte_band.sv
module bcte_band (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  clr,
  input  logic                  upd,
  input  logic [30:0]           t,
  input  logic signed [23:0]    v,
  input  logic signed [31:0]    base101,
  input  logic [22:0]           center,
  input  logic [22:0]           half,
  output bcte_pkg::band_t       st
);

  bcte_pkg::band_t st_r, st_nxt;
  logic signed [34:0] lo, hi, x;
  logic signed [34:0] c35, h35;

  always_comb begin
    c35 = $signed(35'(center));
    h35 = $signed(35'(half));
    lo = 35'(base101) + (c35 - h35) * 35'sd100;
    hi = 35'(base101) + (c35 + h35) * 35'sd100;
    x  = 35'(v) * 35'sd100;
    st_nxt = st_r;
    if (clr) begin
      st_nxt = '0;
    end else if (upd && !st_r.closed && x > lo) begin
      if (x < hi) begin
        if (st_r.hits < bcte_pkg::HIT_W'(bcte_pkg::MAX_SAMPLES)) begin
          st_nxt.tsum = st_r.tsum + bcte_pkg::TSUM_W'(t);
          st_nxt.lsum = st_r.lsum + bcte_pkg::LSUM_W'(v);
          st_nxt.hits = st_r.hits + 1'b1;
        end
      end else begin
        if (st_r.hits == '0) begin
          st_nxt.tsum = bcte_pkg::TSUM_W'(t);
          st_nxt.lsum = bcte_pkg::LSUM_W'(v);
          st_nxt.hits = bcte_pkg::HIT_W'(1);
        end
        st_nxt.closed = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= '0;
    else        st_r <= st_nxt;
  end

  assign st = st_r;

endmodule

>>> design/bcte_div.sv
// restoring divider, one quotient bit per cycle, magnitudes only
module bcte_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [55:0] num,
  input  logic [16:0] den,
  output logic [55:0] quo,
  output logic [16:0] rem,
  output logic        done
);

  logic [55:0] q_r;
  logic [17:0] r_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [17:0] sh, df;

  always_comb begin
    sh = {r_r[16:0], q_r[55]};
    df = sh - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd55;
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= num;
      r_r <= '0;
    end else if (busy_r) begin
      if (!df[17]) begin
        r_r <= df;
        q_r <= {q_r[54:0], 1'b1};
      end else begin
        r_r <= sh;
        q_r <= {q_r[54:0], 1'b0};
      end
    end
  end

  assign quo  = q_r;
  assign rem  = r_r[16:0];
  assign done = done_r;

endmodule

>>> design/band_crossing_time_extractor_core.sv
// channel | dir | tdata (low bit up)                          | tuser | tlast
// in      | in  | sample_time[30:0], sample_value[54:31]      | -     | last
// out     | out | r_found, r_time, r_level, k_found, k_time,  | -     | -
//         |     | k_level, angle_valid, angle (132 bits, pad) |       |
// cfg     | in  | cfg_we, cfg_index[2:0], cfg_data[23:0]      |       |
// a non-last word is band-compared and accumulated as it is taken
// a last word runs the shared 56-bit divider up to six times, then a normalize
// shift and the cordic
// in_tready is low during that work; the result waits in the output register
// rst_n is synchronous; it clears the sums, the sequencer and the output valid
module band_crossing_time_extractor_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [55:0]  in_tdata,   // sample_time[30:0], sample_value[54:31]
  input  logic         in_tlast,   // last
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // r_found, r_time, r_level, k_found, k_time,
                                   // k_level, angle_valid, angle
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [23:0]  cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0, S_RT = 4'd1, S_RL = 4'd2, S_KT = 4'd3,
                         S_KL = 4'd4, S_RD = 4'd5, S_KD = 4'd6, S_NORM = 4'd7,
                         S_CORD = 4'd8, S_OUT = 4'd9, S_WAIT = 4'd10;

  // configuration
  logic signed [23:0] baseline_r;
  logic [22:0] rc_r, rh_r, kc_r, kh_r;
  logic [15:0] tdiv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      baseline_r <= '0;
      rc_r <= 23'd3840; rh_r <= 23'd576;
      kc_r <= 23'd46080; kh_r <= 23'd4608;
      tdiv_r <= 16'd600;
    end else if (cfg_we) begin
      case (cfg_index)
        bcte_pkg::REG_BASELINE: baseline_r <= cfg_data;
        bcte_pkg::REG_R_CENTER: rc_r <= cfg_data[22:0];
        bcte_pkg::REG_R_HALF:   rh_r <= cfg_data[22:0];
        bcte_pkg::REG_K_CENTER: kc_r <= cfg_data[22:0];
        bcte_pkg::REG_K_HALF:   kh_r <= cfg_data[22:0];
        bcte_pkg::REG_TDIV:     tdiv_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic [3:0] state_r;
  logic acc;
  assign in_tready = (state_r == S_IDLE);
  assign acc = in_tvalid && in_tready;

  logic [30:0] t_in;
  logic signed [23:0] v_in;
  assign t_in = in_tdata[30:0];
  assign v_in = in_tdata[54:31];

  logic [30:0] first_r;
  logic have_first_r;
  logic clr;
  logic signed [31:0] base101;
  assign base101 = 32'(baseline_r) * 32'sd101;

  bcte_pkg::band_t rb, kb;
  bcte_band u_r (.clk, .rst_n, .clr, .upd(acc), .t(t_in), .v(v_in),
                 .base101, .center(rc_r), .half(rh_r), .st(rb));
  bcte_band u_k (.clk, .rst_n, .clr, .upd(acc), .t(t_in), .v(v_in),
                 .base101, .center(kc_r), .half(kh_r), .st(kb));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_first_r <= 1'b0;
      first_r <= '0;
    end else if (clr) begin
      have_first_r <= 1'b0;
    end else if (acc && !have_first_r) begin
      have_first_r <= 1'b1;
      first_r <= t_in;
    end
  end

  // shared divider
  logic dv_start, dv_done;
  logic [55:0] dv_num, dv_quo;
  logic [16:0] dv_den, dv_rem;
  bcte_div u_div (.clk, .rst_n, .start(dv_start), .num(dv_num), .den(dv_den),
                  .quo(dv_quo), .rem(dv_rem), .done(dv_done));

  // results and work registers
  logic        rf_r, kf_r, av_r, going_r;
  logic [47:0] rat_r, kat_r;
  logic signed [23:0] rl_r, kl_r;
  logic [31:0] rtime_r;
  logic signed [32:0] ktime_r;
  logic signed [48:0] d_r;
  logic signed [63:0] cx_r, cy_r;
  logic signed [31:0] cz_r;
  logic [4:0] it_r;
  logic out_v_r;
  logic out_load;

  // result moves into the output register once it is free
  assign out_load = (state_r == S_OUT) && (!out_v_r || out_tready);

  logic [15:0] div1;
  assign div1 = (tdiv_r == '0) ? 16'd1 : tdiv_r;

  // floor level average from sign-magnitude quotient
  function automatic logic signed [23:0] lvl_fix(input logic neg, input logic [55:0] q,
                                                 input logic [16:0] r);
    logic signed [56:0] s;
    s = neg ? -$signed({1'b0, q}) - ((r != '0) ? 57'sd1 : 57'sd0)
            : $signed({1'b0, q});
    return s[23:0];
  endfunction

  logic signed [63:0] ay, mx;
  logic signed [63:0] xs, ys;
  logic signed [31:0] v_ang;
  logic [48:0] dmag;
  always_comb begin
    ay = cy_r[63] ? -cy_r : cy_r;
    mx = (cx_r > ay) ? cx_r : ay;
    xs = cx_r >>> it_r;
    ys = cy_r >>> it_r;
    v_ang = 32'sd5898240 - cz_r;
    dmag = d_r[48] ? 49'(-d_r) : 49'(d_r);
  end

  // rounded and clamped angle, zero when not valid
  logic [15:0] ang_val;
  always_comb begin
    if (!av_r || v_ang < 0) ang_val = '0;
    else if (((v_ang + 32'sd128) >>> 8) > 32'sd46080) ang_val = 16'd46080;
    else ang_val = 16'((v_ang + 32'sd128) >>> 8);
  end

  always_comb begin
    dv_start = 1'b0;
    dv_num = '0;
    dv_den = '0;
    case (state_r)
      S_RT: begin dv_num = 56'(rb.tsum); dv_den = 17'(rb.hits); end
      S_RL: begin
        dv_num = rb.lsum[39] ? 56'($unsigned(-rb.lsum)) : 56'($unsigned(rb.lsum));
        dv_den = 17'(rb.hits);
      end
      S_KT: begin dv_num = 56'(kb.tsum); dv_den = 17'(kb.hits); end
      S_KL: begin
        dv_num = kb.lsum[39] ? 56'($unsigned(-kb.lsum)) : 56'($unsigned(kb.lsum));
        dv_den = 17'(kb.hits);
      end
      S_RD, S_KD: begin dv_num = {dmag[47:0], 8'd0}; dv_den = 17'(div1); end
      default: ;
    endcase
    dv_start = !going_r && (state_r >= S_RT) && (state_r <= S_KD);
  end

  assign clr = (state_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      going_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (out_load) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
      if (dv_start) going_r <= 1'b1;
      case (state_r)
        S_IDLE: if (acc && in_tlast) state_r <= S_WAIT;
        S_WAIT: begin
          rf_r <= rb.hits != '0;
          kf_r <= (rb.hits != '0) && (kb.hits != '0);
          rtime_r <= '0; rl_r <= '0; ktime_r <= '0; kl_r <= '0;
          av_r <= 1'b0; rat_r <= '0;
          state_r <= (rb.hits != '0) ? S_RT : S_OUT;
        end
        S_RT: if (dv_done) begin
          going_r <= 1'b0; rat_r <= dv_quo[47:0]; state_r <= S_RL;
        end
        S_RL: if (dv_done) begin
          going_r <= 1'b0;
          rl_r <= lvl_fix(rb.lsum[39], dv_quo, dv_rem);
          d_r <= $signed({1'b0, rat_r}) - $signed(49'(first_r));
          state_r <= S_RD;
        end
        S_RD: if (dv_done) begin
          going_r <= 1'b0;
          if (!d_r[48] && d_r != '0)
            rtime_r <= (dv_quo[55:32] != '0) ? 32'hFFFFFFFF : dv_quo[31:0];
          state_r <= kf_r ? S_KT : S_OUT;
        end
        S_KT: if (dv_done) begin
          going_r <= 1'b0; kat_r <= dv_quo[47:0]; state_r <= S_KL;
        end
        S_KL: if (dv_done) begin
          going_r <= 1'b0;
          kl_r <= lvl_fix(kb.lsum[39], dv_quo, dv_rem);
          d_r <= $signed({1'b0, kat_r}) - $signed({1'b0, rat_r});
          state_r <= S_KD;
        end
        S_KD: if (dv_done) begin
          going_r <= 1'b0;
          if (!d_r[48])
            ktime_r <= (dv_quo[55:32] != '0) ? 33'sh0FFFFFFFF : $signed({1'b0, dv_quo[31:0]});
          else
            ktime_r <= (dv_quo[55:32] != '0) ? -33'sh100000000 :
                       -$signed({1'b0, dv_quo[31:0]});
          if (!d_r[48] && d_r != '0) begin
            av_r <= 1'b1;
            cx_r <= 64'(d_r) <<< 8;
            cy_r <= 64'(kl_r) - 64'(rl_r);
            cz_r <= '0;
            it_r <= '0;
            state_r <= S_NORM;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_NORM: begin
          if (mx >= (64'sd1 <<< 40)) state_r <= S_CORD;
          else begin cx_r <= cx_r <<< 1; cy_r <= cy_r <<< 1; end
        end
        S_CORD: begin
          if (cy_r > 0) begin
            cx_r <= cx_r + ys; cy_r <= cy_r - xs;
            cz_r <= cz_r + $signed({10'd0, bcte_pkg::atan_deg(it_r)});
          end else begin
            cx_r <= cx_r - ys; cy_r <= cy_r + xs;
            cz_r <= cz_r - $signed({10'd0, bcte_pkg::atan_deg(it_r)});
          end
          it_r <= it_r + 1'b1;
          if (it_r == 5'(bcte_pkg::CORDIC_STEPS - 1)) state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  logic [131:0] pay_r;
  always_ff @(posedge clk) begin
    if (out_load) begin
      pay_r <= {ang_val, av_r, kl_r, ktime_r, kf_r, rl_r, rtime_r, rf_r};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata = {4'd0, pay_r};

endmodule

>>> tb/bcte_checker.sv
`timescale 1ns / 1ps

module bcte_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [55:0]  in_tdata,
  input  logic         in_tlast,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [135:0] out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [23:0]  cfg_data,
  output int           errors,
  output int           pending,
  output int           records_seen
);

  // highest field first, so r_found lands in bit 0
  typedef struct packed {
    logic [15:0] angle;
    logic        angle_valid;
    logic [23:0] k_level;
    logic [32:0] k_time;
    logic        k_found;
    logic [23:0] r_level;
    logic [31:0] r_time;
    logic        r_found;
  } crossing_t;

  typedef struct {
    longint tsum;
    longint lsum;
    longint hits;
    bit     closed;
  } band_acc_t;

  crossing_t crossing_q[$];

  longint    base_lvl, r_ctr, r_hw, k_ctr, k_hw, tdiv;
  longint    t0;
  bit        t0_valid;
  band_acc_t r_acc, k_acc;

  function automatic band_acc_t band_step(band_acc_t a, longint t, longint v,
                                          longint c, longint h);
    longint lo, hi, x;
    lo = 101 * base_lvl + 100 * (c - h);
    hi = 101 * base_lvl + 100 * (c + h);
    x  = 100 * v;
    if (a.closed || x <= lo) return a;
    if (x < hi) begin
      if (a.hits < bcte_pkg::MAX_SAMPLES) begin
        a.tsum += t;
        a.lsum += v;
        a.hits++;
      end
    end else begin
      if (a.hits == 0) begin
        a.tsum = t;
        a.lsum = v;
        a.hits = 1;
      end
      a.closed = 1;
    end
    return a;
  endfunction

  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  // 90 - atan2(dy, dx) in Q8.8, dx in ticks and dy in Q16.8
  function automatic longint slope_angle(longint dx, longint dy);
    longint x, y, z, m, xs, ys, v;
    x = dx * 256;
    y = dy;
    z = 0;
    forever begin
      m = (y < 0) ? -y : y;
      if (x > m) m = x;
      if (m >= (64'sd1 <<< 40)) break;
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < bcte_pkg::CORDIC_STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += longint'(bcte_pkg::atan_deg(i[4:0]));
      end else begin
        x -= ys; y += xs; z -= longint'(bcte_pkg::atan_deg(i[4:0]));
      end
    end
    v = 90 * 65536 - z;
    if (v < 0) v = 0;
    v = (v + 128) >>> 8;
    if (v > 46080) v = 46080;
    return v;
  endfunction

  function automatic crossing_t close_record();
    crossing_t e;
    longint    div, r_avg, k_avg, r_lvl, k_lvl, d, q;
    e     = '0;
    div   = (tdiv == 0) ? 1 : tdiv;
    r_avg = 0;
    if (r_acc.hits > 0) begin
      e.r_found = 1;
      r_avg     = r_acc.tsum / r_acc.hits;
      r_lvl     = floor_quot(r_acc.lsum, r_acc.hits);
      e.r_level = r_lvl[23:0];
      d = r_avg - t0;
      if (d > 0) begin
        q = (d * 256) / div;
        e.r_time = (q > 64'sh0FFFFFFFF) ? 32'hFFFFFFFF : q[31:0];
      end
      // k only counts once r is there
      if (k_acc.hits > 0) begin
        e.k_found = 1;
        k_avg     = k_acc.tsum / k_acc.hits;
        k_lvl     = floor_quot(k_acc.lsum, k_acc.hits);
        e.k_level = k_lvl[23:0];
        d = k_avg - r_avg;
        q = (d * 256) / div;
        if (q > 64'sh0FFFFFFFF) q = 64'sh0FFFFFFFF;
        if (q < -64'sh100000000) q = -64'sh100000000;
        e.k_time = q[32:0];
        if (d > 0) begin
          e.angle_valid = 1;
          q = slope_angle(d, k_lvl - r_lvl);
          e.angle = q[15:0];
        end
      end
    end
    return e;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    crossing_t got, want;
    longint    t, v;
    if (!rst_n) begin
      base_lvl = 0; r_ctr = 3840; r_hw = 576; k_ctr = 46080; k_hw = 4608; tdiv = 600;
      t0 = 0; t0_valid = 0;
      r_acc = '{0, 0, 0, 0};
      k_acc = '{0, 0, 0, 0};
      crossing_q.delete();
      errors = 0;
      records_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bcte_pkg::REG_BASELINE: base_lvl = longint'(signed'(cfg_data));
          bcte_pkg::REG_R_CENTER: r_ctr = cfg_data[22:0];
          bcte_pkg::REG_R_HALF:   r_hw  = cfg_data[22:0];
          bcte_pkg::REG_K_CENTER: k_ctr = cfg_data[22:0];
          bcte_pkg::REG_K_HALF:   k_hw  = cfg_data[22:0];
          bcte_pkg::REG_TDIV:     tdiv  = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        t = in_tdata[30:0];
        v = longint'(signed'(in_tdata[54:31]));
        if (!t0_valid) begin
          t0 = t;
          t0_valid = 1;
        end
        r_acc = band_step(r_acc, t, v, r_ctr, r_hw);
        k_acc = band_step(k_acc, t, v, k_ctr, k_hw);
        if (in_tlast) begin
          crossing_q.push_back(close_record());
          t0 = 0; t0_valid = 0;
          r_acc = '{0, 0, 0, 0};
          k_acc = '{0, 0, 0, 0};
        end
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[131:0];
        records_seen++;
        if (crossing_q.size() == 0) begin
          $error("result word with no record pending");
          errors++;
        end else begin
          want = crossing_q.pop_front();
          check_field("r_found", want.r_found, got.r_found);
          check_field("r_time", want.r_time, got.r_time);
          check_field("r_level", want.r_level, got.r_level);
          check_field("k_found", want.k_found, got.k_found);
          check_field("k_time", want.k_time, got.k_time);
          check_field("k_level", want.k_level, got.k_level);
          check_field("angle_valid", want.angle_valid, got.angle_valid);
          check_field("angle", want.angle, got.angle);
        end
      end
    end
    pending = crossing_q.size();
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [55:0]  in_tdata = '0;   // sample_time[30:0], sample_value[54:31]
  logic         in_tlast = 0;    // last
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [135:0] out_tdata;       // r_found, r_time, r_level, k_found, k_time,
                                 // k_level, angle_valid, angle
  logic         cfg_we = 0;
  logic [2:0]   cfg_index = '0;
  logic [23:0]  cfg_data = '0;

  int errors, pending, records_seen;

  // latency of one record close, with margin
  localparam int SETTLE = 600;
  localparam int STALL_LIMIT = 20000;
  localparam int ITEM_GOAL = 1850;

  int  cyc = 0;
  int  idle_cycles = 0;
  int  words_sent = 0;
  int  phases_run = 0;
  bit  burst = 0;
  bit  hold_done = 0;

  // stimulus-side copy of the band settings, used only to aim the ramps
  longint s_base = 0, s_rc = 3840, s_rh = 576, s_kc = 46080, s_kh = 4608;

  always #6 clk = ~clk;

  band_crossing_time_extractor_core dut (.*);

  bcte_checker u_checker (.*);

  // watchdog: nothing moving for too long ends the run
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[band_crossing_time_extractor_core] ERROR");
        $finish;
      end
    end
  end

  // receiver: mostly ready, short and long stalls, one long hold-off
  initial begin
    int r;
    forever begin
      @(posedge clk);
      r = $urandom_range(0, 99);
      if (!hold_done && cyc > 40000) begin
        out_tready <= 0;
        repeat (3000) @(posedge clk);
        hold_done = 1;
      end else if (r < 75) begin
        out_tready <= 1;
      end else if (r < 96) begin
        out_tready <= 0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_tready <= 0;
        repeat ($urandom_range(20, 150)) @(posedge clk);
      end
    end
  end

  // one word on the input, held until taken; gaps only outside bursts
  task automatic send_word(longint t, longint v, bit lst);
    int r;
    in_tvalid <= 1;
    in_tdata  <= {1'b0, v[23:0], t[30:0]};
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
    r = $urandom_range(0, 99);
    if (!burst && r >= 70) begin
      in_tvalid <= 0;
      if (r < 96) repeat ($urandom_range(1, 3)) @(posedge clk);
      else repeat ($urandom_range(20, 80)) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, longint val);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= val[23:0];
    @(posedge clk);
    case (idx)
      bcte_pkg::REG_BASELINE: s_base = longint'(signed'(val[23:0]));
      bcte_pkg::REG_R_CENTER: s_rc = val[22:0];
      bcte_pkg::REG_R_HALF:   s_rh = val[22:0];
      bcte_pkg::REG_K_CENTER: s_kc = val[22:0];
      bcte_pkg::REG_K_HALF:   s_kh = val[22:0];
      default: ;
    endcase
  endtask

  // drain, then load a full band setting
  task automatic load_setting(longint bl, longint rc, longint rh, longint kc,
                              longint kh, longint dv);
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    write_reg(bcte_pkg::REG_BASELINE, bl);
    write_reg(bcte_pkg::REG_R_CENTER, rc);
    write_reg(bcte_pkg::REG_R_HALF, rh);
    write_reg(bcte_pkg::REG_K_CENTER, kc);
    write_reg(bcte_pkg::REG_K_HALF, kh);
    write_reg(bcte_pkg::REG_TDIV, dv);
    write_reg(3'd6, $urandom);  // unmapped index, must be ignored
    write_reg(3'd7, $urandom);
    cfg_we <= 0;
    @(posedge clk);
    phases_run++;
  endtask

  function automatic longint clamp_lvl(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // a record: mostly a ramp climbing through both bands, sometimes noise
  task automatic run_record();
    int     n, mode;
    longint t, lo, hi, v, top;
    n    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(2, 14);
    mode = $urandom_range(0, 99);
    t    = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 32'h7FF00000);
    burst = ($urandom_range(0, 3) == 0);
    lo  = s_base + s_base / 100 - 256 * $urandom_range(0, 4);
    top = s_kc + s_kh;
    if (s_rc + s_rh > top) top = s_rc + s_rh;
    hi  = lo + top + top / 8 + 512;
    for (int i = 0; i < n; i++) begin
      if (mode < 80) begin
        v = lo + ((hi - lo) * i) / ((n > 1) ? n - 1 : 1) + $urandom_range(0, 64) - 32;
      end else begin
        v = longint'(signed'(24'($urandom)));
      end
      if (mode >= 93) t = $urandom_range(0, 32'h7FFFFFFF);  // out of order times
      else t = t + $urandom_range(1, 3000);
      send_word(t, clamp_lvl(v), i == n - 1);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: single-word record at the field extremes
    send_word(0, -8388608, 1);
    send_word(32'h7FFFFFFF, 8388607, 1);
    // nothing reaches r
    send_word(100, 0, 0);
    send_word(200, 256, 1);
    // r only, then closing sample alone in r
    send_word(1000, 3500, 0);
    send_word(1600, 4000, 0);
    send_word(2200, 3000, 1);
    send_word(5000, 5000, 1);
    // full climb through r and k
    send_word(10, 3300, 0);
    send_word(700, 4300, 0);
    send_word(1300, 42000, 0);
    send_word(1900, 50000, 0);
    send_word(2500, 60000, 1);
    // r time before first time, k before r
    send_word(90000, 100, 0);
    send_word(100, 4000, 0);
    send_word(50, 45000, 1);
    // k directly above the r band: r keeps the closing sample alone
    send_word(3000, 45000, 0);
    send_word(3600, 44000, 1);

    // k band below r band, so k can get hits while r stays empty
    load_setting(0, 46080, 4608, 3840, 576, 0);
    send_word(10, 4000, 0);
    send_word(20, 2000, 1);
    send_word(30, 4000, 0);
    send_word(90, 40000, 1);

    while (words_sent < ITEM_GOAL) begin
      case (phases_run % 8)
        0: load_setting(0, 3840, 576, 46080, 4608, 600);
        1: load_setting(-8388608, 8388607, 8388607, 8388607, 8388607, 1);
        2: load_setting(8388607, 0, 0, 0, 0, 65535);
        3: load_setting(-25600, 3840, 576, 46080, 4608, 1);
        4: load_setting(2560, 0, 256, 8388607, 0, 7);
        5: load_setting($urandom_range(0, 20000) - 10000, $urandom_range(0, 8000),
                        $urandom_range(0, 2000), $urandom_range(8000, 80000),
                        $urandom_range(0, 20000), $urandom_range(1, 65535));
        6: load_setting(32'h800000 | $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom);
        default: load_setting(-3000, 3840, 576, 46080, 4608, 600);
      endcase
      repeat (30) run_record();
    end

    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d sample words and %0d records over %0d band settings",
             words_sent, records_seen, phases_run);
    $display("with random gaps on both sides and one long output hold-off");
    if (errors == 0 && pending == 0) begin
      $display("[band_crossing_time_extractor_core] OK");
    end else begin
      $display("[band_crossing_time_extractor_core] ERROR");
    end
    $finish;
  end

endmodule
